>>> rtl/msie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msie_pkg
// Shared types and constants for the integer subset instruction executor.
// ----------------------------------------------------------------------------
package msie_pkg;

  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_JAL     = 6'd3;
  localparam logic [5:0] OPC_ADDI    = 6'd8;
  localparam logic [5:0] OPC_ADDIU   = 6'd9;

  localparam logic [5:0] FN_SYSCALL  = 6'd12;
  localparam logic [5:0] FN_ADD      = 6'd32;
  localparam logic [5:0] FN_ADDU     = 6'd33;
  localparam logic [5:0] FN_SUB      = 6'd34;
  localparam logic [5:0] FN_AND      = 6'd36;

  localparam logic [4:0] REG_ZERO    = 5'd0;
  localparam logic [4:0] REG_V0      = 5'd2;
  localparam logic [4:0] REG_A0      = 5'd4;
  localparam logic [4:0] REG_RA      = 5'd31;

  localparam logic [31:0] SYS_PRINT_INT = 32'd1;
  localparam logic [31:0] SYS_EXIT      = 32'd10;

  localparam logic [31:0] START_PC_RESET = 32'h0040_0000;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_AND,
    OP_ADDI,
    OP_J,
    OP_JAL,
    OP_SYSCALL
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dst;
    logic [31:0] imm;
    logic [25:0] target;
  } uop_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> rtl/msie_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msie_front
// Accepts instruction items and decodes them into micro-ops for the queue.
// ----------------------------------------------------------------------------
module msie_front
  import msie_pkg::*;
(
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_word_i,
  input  wire q_status_t   q_status_i,
  output logic             push_o,
  output uop_t             uop_o
);

  logic [5:0] opc;
  logic [5:0] fn;

  assign opc        = instruction_word_i[31:26];
  assign fn         = instruction_word_i[5:0];
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    uop_o.op     = OP_NOP;
    uop_o.rs     = instruction_word_i[25:21];
    uop_o.rt     = instruction_word_i[20:16];
    uop_o.dst    = instruction_word_i[15:11];
    uop_o.imm    = {{16{instruction_word_i[15]}}, instruction_word_i[15:0]};
    uop_o.target = instruction_word_i[25:0];
    case (opc)
      OPC_SPECIAL: begin
        case (fn)
          FN_ADD:     uop_o.op = OP_ADD;
          FN_ADDU:    uop_o.op = OP_ADD;
          FN_SUB:     uop_o.op = OP_SUB;
          FN_AND:     uop_o.op = OP_AND;
          FN_SYSCALL: uop_o.op = OP_SYSCALL;
          default:    uop_o.op = OP_NOP;
        endcase
      end
      OPC_ADDI, OPC_ADDIU: begin
        uop_o.op  = OP_ADDI;
        uop_o.dst = instruction_word_i[20:16];
      end
      OPC_J: uop_o.op = OP_J;
      OPC_JAL: begin
        uop_o.op  = OP_JAL;
        uop_o.dst = REG_RA;
      end
      default: uop_o.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/msie_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msie_queue
// Small micro-op queue between decode and execute.
// ----------------------------------------------------------------------------
module msie_queue
  import msie_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire uop_t  push_data_i,
  input  wire logic  pop_i,
  output uop_t       head_o,
  output q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  uop_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/msie_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msie_back
// Operand read, execute and commit: register file, PC, halt and result register.
// ----------------------------------------------------------------------------
module msie_back
  import msie_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire uop_t        head_i,
  input  wire logic        q_empty_i,
  output logic             pop_o,
  input  wire logic        cfg_write_i,
  input  wire logic [31:0] cfg_start_pc_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      next_pc_o,
  output logic             reg_write_valid_o,
  output logic [4:0]       reg_write_index_o,
  output logic [31:0]      reg_write_value_o,
  output logic             print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic             halted_o,
  output logic             halt_o
);

  logic        ex_valid_q, ex_valid_d;
  uop_t        ex_uop_q;
  logic [31:0] opa_q, opb_q;

  logic [31:0] rf_q [32];
  logic [31:0] rf_vld_q;
  logic [31:0] v0_q, a0_q;
  logic [31:0] pc_q;
  logic        halt_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_pc_q;
  logic        out_wr_q;
  logic [4:0]  out_idx_q;
  logic [31:0] out_val_q;
  logic        out_pr_q;
  logic [31:0] out_pval_q;
  logic        out_halt_q;

  logic        fire, issue;
  logic [31:0] pc4, nxt;
  logic        wr, pr, set_halt;
  logic [4:0]  widx;
  logic [31:0] wval, pval;
  logic        commit_wr;

  assign fire      = ex_valid_q && (!out_valid_q || !out_stall_i);
  assign issue     = !q_empty_i && (!ex_valid_q || fire);
  assign pop_o     = issue;
  assign commit_wr = fire && wr;
  assign halt_o    = halt_q;

  always_comb begin
    pc4      = pc_q + 32'd4;
    nxt      = pc4;
    wr       = 1'b0;
    widx     = REG_ZERO;
    wval     = '0;
    pr       = 1'b0;
    pval     = '0;
    set_halt = 1'b0;
    case (ex_uop_q.op)
      OP_ADD: begin
        wr = 1'b1; widx = ex_uop_q.dst; wval = opa_q + opb_q;
      end
      OP_SUB: begin
        wr = 1'b1; widx = ex_uop_q.dst; wval = opa_q - opb_q;
      end
      OP_AND: begin
        wr = 1'b1; widx = ex_uop_q.dst; wval = opa_q & opb_q;
      end
      OP_ADDI: begin
        wr = 1'b1; widx = ex_uop_q.dst; wval = opa_q + ex_uop_q.imm;
      end
      OP_J: nxt = {pc4[31:28], ex_uop_q.target, 2'b00};
      OP_JAL: begin
        nxt = {pc4[31:28], ex_uop_q.target, 2'b00};
        wr = 1'b1; widx = ex_uop_q.dst; wval = pc4;
      end
      OP_SYSCALL: begin
        if (v0_q == SYS_EXIT) begin
          set_halt = 1'b1;
        end else if (v0_q == SYS_PRINT_INT) begin
          pr = 1'b1; pval = a0_q;
        end
      end
      default: nxt = pc4;
    endcase
    if (widx == REG_ZERO) begin
      wr = 1'b0;
    end
    if (!wr) begin
      widx = REG_ZERO;
      wval = '0;
    end
    if (halt_q) begin
      nxt  = pc_q;
      wr   = 1'b0;
      widx = REG_ZERO;
      wval = '0;
      pr   = 1'b0;
      pval = '0;
      set_halt = 1'b0;
    end
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    if (issue) begin
      ex_valid_d = 1'b1;
    end else if (fire) begin
      ex_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  // operand capture, bypassing the write that commits on the same edge
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ex_uop_q <= head_i;
      if (commit_wr && (widx == head_i.rs)) begin
        opa_q <= wval;
      end else if (rf_vld_q[head_i.rs]) begin
        opa_q <= rf_q[head_i.rs];
      end else begin
        opa_q <= '0;
      end
      if (commit_wr && (widx == head_i.rt)) begin
        opb_q <= wval;
      end else if (rf_vld_q[head_i.rt]) begin
        opb_q <= rf_q[head_i.rt];
      end else begin
        opb_q <= '0;
      end
    end
    if (commit_wr) begin
      rf_q[widx] <= wval;
    end
    if (fire) begin
      out_pc_q   <= nxt;
      out_wr_q   <= wr;
      out_idx_q  <= widx;
      out_val_q  <= wval;
      out_pr_q   <= pr;
      out_pval_q <= pval;
      out_halt_q <= halt_q || set_halt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rf_vld_q    <= '0;
      v0_q        <= '0;
      a0_q        <= '0;
      pc_q        <= START_PC_RESET;
      halt_q      <= 1'b0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
      if (commit_wr) begin
        rf_vld_q[widx] <= 1'b1;
        if (widx == REG_V0) begin
          v0_q <= wval;
        end
        if (widx == REG_A0) begin
          a0_q <= wval;
        end
      end
      if (fire) begin
        pc_q <= nxt;
        if (set_halt) begin
          halt_q <= 1'b1;
        end
      end
      if (cfg_write_i) begin
        pc_q <= cfg_start_pc_i;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = out_pc_q;
  assign reg_write_valid_o = out_wr_q;
  assign reg_write_index_o = out_idx_q;
  assign reg_write_value_o = out_val_q;
  assign print_valid_o     = out_pr_q;
  assign print_value_o     = $signed(out_pval_q);
  assign halted_o          = out_halt_q;

endmodule
`default_nettype wire

>>> rtl/mips_subset_instruction_executor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_core
// Integer subset core: decode front end, micro-op queue, execute back end.
// ----------------------------------------------------------------------------
// One instruction item is retired per clock in steady state while out_stall_i is low;
// an item passes through the queue slot written when it is accepted, the
// operand registers (register file read with same-edge bypass) and the result
// register. Throughput is set by the
// single execute stage, whose operands come from the registered read port of
// the 32x32 register file. Writing start_pc reloads the program counter; do it
// only while no item is in flight.
module mips_subset_instruction_executor_core
  import msie_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_word_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_start_pc_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      next_pc_o,
  output logic             reg_write_valid_o,
  output logic [4:0]       reg_write_index_o,
  output logic [31:0]      reg_write_value_o,
  output logic             print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic             halted_o
);

  q_status_t q_status;
  logic      push, pop;
  uop_t      push_uop, head_uop;
  logic      halt;

  assign cfg_ready_o = 1'b1;

  msie_front u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .instruction_word_i (instruction_word_i),
    .q_status_i         (q_status),
    .push_o             (push),
    .uop_o              (push_uop)
  );

  msie_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_uop),
    .pop_i       (pop),
    .head_o      (head_uop),
    .status_o    (q_status)
  );

  msie_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head_uop),
    .q_empty_i         (q_status.empty),
    .pop_o             (pop),
    .cfg_write_i       (cfg_valid_i && cfg_ready_o),
    .cfg_start_pc_i    (cfg_start_pc_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .next_pc_o         (next_pc_o),
    .reg_write_valid_o (reg_write_valid_o),
    .reg_write_index_o (reg_write_index_o),
    .reg_write_value_o (reg_write_value_o),
    .print_valid_o     (print_valid_o),
    .print_value_o     (print_value_o),
    .halted_o          (halted_o),
    .halt_o            (halt)
  );

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt |=> halt)
    else $error("halt mark cleared");

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty");

  a_no_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reg_write_valid_o) |-> (reg_write_index_o != REG_ZERO))
    else $error("write to register zero reported");

  a_print_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(print_valid_o && (reg_write_valid_o || halted_o)))
    else $error("print alongside write or halt");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the integer subset instruction executor core.
// A directed program walks register file, arithmetic wrap, discarded writes
// to register zero, jumps, prints and unknown encodings. Random phases then
// follow under several start_pc values. The run ends with a halt and a
// reload of the program counter after the halt. Every retired item is
// compared field by field with an in-order architectural predictor or a fixed want.
// ----------------------------------------------------------------------------
module testbench;
  import msie_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 250;
  localparam int unsigned PipeSlack  = 6;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic               wr_valid;
    logic [4:0]         wr_index;
    logic [31:0]        wr_value;
    logic               pr_valid;
    logic signed [31:0] pr_value;
    logic               halted;
  } retire_t;

  typedef struct {
    logic [31:0] word;
    logic        fixed;
    retire_t     want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [31:0]        instruction_word_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [31:0]        cfg_start_pc_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [31:0]        next_pc_o;
  logic               reg_write_valid_o;
  logic [4:0]         reg_write_index_o;
  logic [31:0]        reg_write_value_o;
  logic               print_valid_o;
  logic signed [31:0] print_value_o;
  logic               halted_o;

  mips_subset_instruction_executor_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .instruction_word_i (instruction_word_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_start_pc_i     (cfg_start_pc_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .next_pc_o          (next_pc_o),
    .reg_write_valid_o  (reg_write_valid_o),
    .reg_write_index_o  (reg_write_index_o),
    .reg_write_value_o  (reg_write_value_o),
    .print_valid_o      (print_valid_o),
    .print_value_o      (print_value_o),
    .halted_o           (halted_o)
  );

  // architectural state of the predictor
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic        arch_halted;

  retire_t     pending_retire [$];
  stim_row_t   program_rows [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned holds_asked;
  int unsigned holds_served;
  int unsigned hold_left;
  logic        quiet;
  logic        halt_ok;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [5:0] fn);
    return {OPC_SPECIAL, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] jtype(logic [5:0] op, logic [25:0] target);
    return {op, target};
  endfunction

  function automatic retire_t outcome(logic [31:0] npc, logic wv, logic [4:0] wi,
                                      logic [31:0] wval);
    retire_t r;
    r = '0;
    r.next_pc  = npc;
    r.wr_valid = wv;
    r.wr_index = wi;
    r.wr_value = wval;
    return r;
  endfunction

  function automatic stim_row_t row(logic [31:0] w, logic fixed, retire_t want);
    stim_row_t s;
    s.word  = w;
    s.fixed = fixed;
    s.want  = want;
    return s;
  endfunction

  function automatic op_e classify(logic [31:0] w);
    op_e k;
    k = OP_NOP;
    case (w[31:26])
      OPC_SPECIAL: begin
        case (w[5:0])
          FN_ADD, FN_ADDU: k = OP_ADD;
          FN_SUB:          k = OP_SUB;
          FN_AND:          k = OP_AND;
          FN_SYSCALL:      k = OP_SYSCALL;
          default:         k = OP_NOP;
        endcase
      end
      OPC_ADDI, OPC_ADDIU: k = OP_ADDI;
      OPC_J:               k = OP_J;
      OPC_JAL:             k = OP_JAL;
      default:             k = OP_NOP;
    endcase
    return k;
  endfunction

  // executes one instruction against the architectural state
  function automatic retire_t retire_instr(logic [31:0] w);
    retire_t     r;
    logic [31:0] a, b, pc4, imm, val;
    logic        wr;
    logic [4:0]  idx;
    r = '0;
    if (arch_halted) begin
      r.next_pc = arch_pc;
      r.halted  = 1'b1;
      return r;
    end
    a         = arch_regs[w[25:21]];
    b         = arch_regs[w[20:16]];
    pc4       = arch_pc + 32'd4;
    imm       = {{16{w[15]}}, w[15:0]};
    r.next_pc = pc4;
    wr        = 1'b0;
    idx       = REG_ZERO;
    val       = '0;
    case (classify(w))
      OP_ADD: begin
        wr = 1'b1; idx = w[15:11]; val = a + b;
      end
      OP_SUB: begin
        wr = 1'b1; idx = w[15:11]; val = a - b;
      end
      OP_AND: begin
        wr = 1'b1; idx = w[15:11]; val = a & b;
      end
      OP_ADDI: begin
        wr = 1'b1; idx = w[20:16]; val = a + imm;
      end
      OP_J: begin
        r.next_pc = {pc4[31:28], w[25:0], 2'b00};
      end
      OP_JAL: begin
        r.next_pc = {pc4[31:28], w[25:0], 2'b00};
        wr = 1'b1; idx = REG_RA; val = pc4;
      end
      OP_SYSCALL: begin
        if (arch_regs[REG_V0] == SYS_EXIT) begin
          arch_halted = 1'b1;
        end else if (arch_regs[REG_V0] == SYS_PRINT_INT) begin
          r.pr_valid = 1'b1;
          r.pr_value = arch_regs[REG_A0];
        end
      end
      default: ;
    endcase
    if (wr && idx != REG_ZERO) begin
      arch_regs[idx] = val;
      r.wr_valid     = 1'b1;
      r.wr_index     = idx;
      r.wr_value     = val;
    end
    arch_pc  = r.next_pc;
    r.halted = arch_halted;
    return r;
  endfunction

  function automatic logic [4:0] pick_reg();
    if ($urandom_range(3) == 0) return 5'($urandom_range(31));
    return 5'($urandom_range(7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_instr();
    int unsigned kind;
    logic [5:0]  op;
    logic [5:0]  fn;
    kind = $urandom_range(99);
    if (kind < 10) return $urandom;
    if (kind < 40) begin
      case ($urandom_range(4))
        0: fn = FN_ADD;
        1: fn = FN_ADDU;
        2: fn = FN_SUB;
        3: fn = FN_AND;
        default: fn = 6'($urandom);
      endcase
      return rtype(pick_reg(), pick_reg(), pick_reg(), fn);
    end
    if (kind < 65) begin
      op = ($urandom_range(1) == 0) ? OPC_ADDI : OPC_ADDIU;
      return itype(op, pick_reg(), pick_reg(), pick_imm());
    end
    if (kind < 72) begin
      op = ($urandom_range(1) == 0) ? OPC_J : OPC_JAL;
      return jtype(op, 26'($urandom));
    end
    if (kind < 80) return {OPC_SPECIAL, 20'($urandom), FN_SYSCALL};
    op = 6'($urandom_range(63));
    if (op == OPC_SPECIAL || op == OPC_J || op == OPC_JAL || op == OPC_ADDI ||
        op == OPC_ADDIU) begin
      op = op | 6'h30;
    end
    return {op, 26'($urandom)};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("MISMATCH at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    end
  endtask

  task automatic send_instr(input logic [31:0] w_in, input logic fixed, input retire_t want);
    logic [31:0] w;
    retire_t     r;
    w = w_in;
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    // keep the machine running until the final halt
    if (!halt_ok && classify(w) == OP_SYSCALL && arch_regs[REG_V0] == SYS_EXIT) begin
      w[5:0] = FN_ADDU;
    end
    in_valid_i         <= 1'b1;
    instruction_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    r = retire_instr(w);
    pending_retire.push_back(fixed ? want : r);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_retire.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_start_pc(input logic [31:0] v);
    drain();
    repeat (PipeSlack) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_start_pc_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    arch_pc       = v;
  endtask

  // result side: check, then decide the stall for the next cycle
  always @(posedge clk_i) begin
    retire_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_retire.size() == 0) begin
        report_mismatch("item with nothing pending, next_pc", next_pc_o, '0);
      end else begin
        want = pending_retire.pop_front();
        if (next_pc_o !== want.next_pc)
          report_mismatch("next_pc", next_pc_o, want.next_pc);
        if (reg_write_valid_o !== want.wr_valid)
          report_mismatch("reg_write_valid", 32'(reg_write_valid_o), 32'(want.wr_valid));
        if (reg_write_index_o !== want.wr_index)
          report_mismatch("reg_write_index", 32'(reg_write_index_o), 32'(want.wr_index));
        if (reg_write_value_o !== want.wr_value)
          report_mismatch("reg_write_value", reg_write_value_o, want.wr_value);
        if (print_valid_o !== want.pr_valid)
          report_mismatch("print_valid", 32'(print_valid_o), 32'(want.pr_valid));
        if (print_value_o !== want.pr_value)
          report_mismatch("print_value", print_value_o, want.pr_value);
        if (halted_o !== want.halted)
          report_mismatch("halted", 32'(halted_o), 32'(want.halted));
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = 120;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned first;
    logic [31:0] pc_val;
    logic        mid_done;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    instruction_word_i = '0;
    cfg_valid_i        = 1'b0;
    cfg_start_pc_i     = '0;
    out_stall_i        = 1'b0;
    mismatch_count     = 0;
    cycle_count        = 0;
    items_sent         = 0;
    holds_asked        = 0;
    holds_served       = 0;
    hold_left          = 0;
    quiet              = 1'b0;
    halt_ok            = 1'b0;
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc       = START_PC_RESET;
    arch_halted   = 1'b0;

    // directed program, from the reset program counter
    program_rows.push_back(row(itype(OPC_ADDI, REG_ZERO, 5'd1, 16'hFFFF), 1'b1,
                               outcome(32'h0040_0004, 1'b1, 5'd1, 32'hFFFF_FFFF)));
    program_rows.push_back(row(itype(OPC_ADDIU, REG_ZERO, REG_V0, 16'h8000), 1'b1,
                               outcome(32'h0040_0008, 1'b1, REG_V0, 32'hFFFF_8000)));
    program_rows.push_back(row(itype(OPC_ADDI, REG_ZERO, 5'd3, 16'h7FFF), 1'b1,
                               outcome(32'h0040_000C, 1'b1, 5'd3, 32'h0000_7FFF)));
    program_rows.push_back(row(32'h0000_0000, 1'b1,
                               outcome(32'h0040_0010, 1'b0, REG_ZERO, '0)));
    program_rows.push_back(row(32'hFFFF_FFFF, 1'b1,
                               outcome(32'h0040_0014, 1'b0, REG_ZERO, '0)));
    program_rows.push_back(row(rtype(5'd1, 5'd1, REG_ZERO, FN_ADD), 1'b1,
                               outcome(32'h0040_0018, 1'b0, REG_ZERO, '0)));
    program_rows.push_back(row(itype(OPC_ADDI, 5'd3, REG_ZERO, 16'h0001), 1'b1,
                               outcome(32'h0040_001C, 1'b0, REG_ZERO, '0)));
    program_rows.push_back(row(rtype(5'd1, 5'd3, 5'd5, FN_ADD), 1'b0, '0));
    program_rows.push_back(row(rtype(5'd5, 5'd5, 5'd6, FN_ADDU), 1'b0, '0));
    program_rows.push_back(row(rtype(REG_ZERO, 5'd1, 5'd7, FN_SUB), 1'b0, '0));
    program_rows.push_back(row(rtype(REG_V0, 5'd3, 5'd8, FN_SUB), 1'b0, '0));
    program_rows.push_back(row(rtype(5'd1, REG_V0, 5'd9, FN_AND), 1'b0, '0));
    program_rows.push_back(row(rtype(5'd1, REG_V0, 5'd10, 6'h3F), 1'b0, '0));
    program_rows.push_back(row(rtype(REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 1'b0, '0));
    program_rows.push_back(row(itype(OPC_ADDI, REG_ZERO, REG_V0, 16'h0001), 1'b0, '0));
    program_rows.push_back(row(itype(OPC_ADDIU, REG_ZERO, REG_A0, 16'h8000), 1'b0, '0));
    program_rows.push_back(row(rtype(REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 1'b0, '0));
    program_rows.push_back(row(jtype(OPC_J, 26'h3FF_FFFF), 1'b0, '0));
    program_rows.push_back(row(jtype(OPC_JAL, 26'h000_0000), 1'b0, '0));
    program_rows.push_back(row(rtype(REG_RA, REG_ZERO, 5'd11, FN_ADDU), 1'b0, '0));
    program_rows.push_back(row(itype(OPC_ADDI, REG_RA, REG_A0, 16'hFFFF), 1'b0, '0));
    program_rows.push_back(row(rtype(REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 1'b0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (program_rows[i]) begin
      send_instr(program_rows[i].word, program_rows[i].fixed, program_rows[i].want);
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: pc_val = 32'h0000_0000;
        1: pc_val = 32'hFFFF_FFFC;
        2: pc_val = 32'hFFFF_FFFF;
        3: pc_val = $urandom;
        default: pc_val = START_PC_RESET;
      endcase
      load_start_pc(pc_val);
      quiet = (ph == 0);
      first = items_sent;
      mid_done = 1'b0;
      while (items_sent - first < PhaseItems) begin
        if (!mid_done && (ph == 1 || ph == 3) && items_sent - first >= 100) begin
          holds_asked++;
          mid_done = 1'b1;
        end
        if (!mid_done && ph == 2 && items_sent - first >= 125) begin
          drain();
          mid_done = 1'b1;
        end
        case ($urandom_range(49))
          0, 1, 2: begin
            send_instr(itype(OPC_ADDI, REG_ZERO, REG_V0, 16'h0001), 1'b0, '0);
            send_instr(itype(OPC_ADDIU, pick_reg(), REG_A0, pick_imm()), 1'b0, '0);
            send_instr({OPC_SPECIAL, 20'($urandom), FN_SYSCALL}, 1'b0, '0);
          end
          3: send_instr(itype(OPC_ADDI, REG_ZERO, REG_V0, 16'd10), 1'b0, '0);
          default: send_instr(random_instr(), 1'b0, '0);
        endcase
      end
    end
    quiet = 1'b0;

    // halt, ignored items, then a program counter reload while halted
    drain();
    halt_ok = 1'b1;
    send_instr(itype(OPC_ADDI, REG_ZERO, REG_V0, 16'd10), 1'b0, '0);
    send_instr(rtype(REG_ZERO, REG_ZERO, REG_ZERO, FN_SYSCALL), 1'b0, '0);
    repeat (3) send_instr(random_instr(), 1'b0, '0);
    load_start_pc(32'h1234_5678);
    repeat (3) send_instr(random_instr(), 1'b0, '0);
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_retire.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/msie_pkg.sv
rtl/msie_front.sv
rtl/msie_queue.sv
rtl/msie_back.sv
rtl/mips_subset_instruction_executor_core.sv
tb/sv/testbench.sv
